// ===== rtl/core/velocity_cap_accel_fixup_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the velocity cap unit
// Concurrent checks that simulation evaluates and synthesis leaves out.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_CAP_ACCEL_FIXUP_UNIT_ASSERT_SVH
`define VELOCITY_CAP_ACCEL_FIXUP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge out of reset.
`define VCAF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define VCAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define VCAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define VCAF_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define VCAF_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define VCAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/vcaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity cap package
// Widths, the cap reset value, job codes and the job record shared by all parts.
// ----------------------------------------------------------------------------
package vcaf_pkg;

  localparam int VEL_W = 16;
  localparam int ACC_W = 16;
  localparam int CAP_W = 15;
  localparam int MAG_W = 16;
  localparam int PROD_W = 2 * MAG_W;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS = PROD_W / BITS_PER_STEP;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CAP_W-1:0] MAX_SPEED_RESET = 15'd3840;

  // What the back part does with a job.
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_ZERO = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  typedef struct packed {
    logic [VEL_W-1:0] vel;
    logic             fin;
    op_t              op;
    logic             neg;
    logic [ACC_W-1:0] accel;
    logic [MAG_W-1:0] nmag;
    logic [MAG_W-1:0] amag;
    logic [MAG_W-1:0] gmag;
  } job_t;

endpackage

// ===== rtl/core/vcaf_front.sv =====
// ----------------------------------------------------------------------------
// Velocity cap front part
// Holds one point back, classifies each released point and queues its job.
// ----------------------------------------------------------------------------
`include "velocity_cap_accel_fixup_unit_assert.svh"

module vcaf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vcaf_pkg::CAP_W-1:0]    max_speed,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,
  input  logic                          s_tlast,
  output logic                          push_valid,
  input  logic                          push_ready,
  output vcaf_pkg::job_t                push_job
);

  localparam int VW = vcaf_pkg::VEL_W;

  logic          busy;
  logic [VW-1:0] in_vel;
  logic [VW-1:0] in_acc;
  logic          in_fin;
  logic          held_valid;
  logic [VW-1:0] held_vel;
  logic [VW-1:0] held_acc;

  logic signed [VW:0] cap_w;
  logic signed [VW:0] vi;
  logic signed [VW:0] vn;
  logic signed [VW:0] ci;
  logic signed [VW:0] cn;
  logic signed [VW:0] num;
  logic signed [VW:0] gap;
  logic signed [VW:0] acc_w;
  logic [VW:0]        nmag_w;
  logic [VW:0]        gmag_w;
  logic [VW:0]        amag_w;
  logic               over_i;
  logic               over_n;
  vcaf_pkg::job_t     held_job;
  vcaf_pkg::job_t     final_job;

  assign s_tready = !busy;

  always_comb begin
    cap_w  = $signed({2'b00, max_speed});
    vi     = $signed({held_vel[VW-1], held_vel});
    vn     = $signed({in_vel[VW-1], in_vel});
    acc_w  = $signed({held_acc[VW-1], held_acc});
    over_i = vi > cap_w;
    over_n = vn > cap_w;
    ci     = over_i ? cap_w : vi;
    cn     = over_n ? cap_w : vn;
    num    = cn - ci;
    gap    = vn - vi;
    nmag_w = num[VW] ? $unsigned(-num) : $unsigned(num);
    gmag_w = gap[VW] ? $unsigned(-gap) : $unsigned(gap);
    amag_w = acc_w[VW] ? $unsigned(-acc_w) : $unsigned(acc_w);

    held_job       = '0;
    held_job.vel   = ci[VW-1:0];
    held_job.fin   = 1'b0;
    held_job.neg   = num[VW];
    held_job.accel = held_acc;
    held_job.nmag  = nmag_w[VW-1:0];
    held_job.gmag  = gmag_w[VW-1:0];
    held_job.amag  = (amag_w == '0) ? vcaf_pkg::MAG_W'(1) : amag_w[VW-1:0];
    if (over_i && over_n) begin
      held_job.op = vcaf_pkg::OP_ZERO;
    end else if (!over_i && !over_n) begin
      held_job.op = vcaf_pkg::OP_PASS;
    end else begin
      held_job.op = vcaf_pkg::OP_DIV;
    end

    final_job     = '0;
    final_job.vel = cn[VW-1:0];
    final_job.fin = 1'b1;
    final_job.op  = vcaf_pkg::OP_ZERO;
  end

  // The held point is released first; a final request then sends itself.
  always_comb begin
    push_valid = 1'b0;
    push_job   = held_job;
    if (busy) begin
      if (held_valid) begin
        push_valid = 1'b1;
      end else if (in_fin) begin
        push_valid = 1'b1;
        push_job   = final_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      held_valid <= 1'b0;
      held_vel   <= '0;
      held_acc   <= '0;
    end else if (!busy) begin
      if (s_tvalid) begin
        busy   <= 1'b1;
        in_vel <= s_tdata[VW-1:0];
        in_acc <= s_tdata[2*VW-1:VW];
        in_fin <= s_tlast;
      end
    end else if (held_valid) begin
      if (push_ready) begin
        if (in_fin) begin
          held_valid <= 1'b0;
          held_vel   <= '0;
          held_acc   <= '0;
        end else begin
          held_vel <= in_vel;
          held_acc <= in_acc;
          busy     <= 1'b0;
        end
      end
    end else if (in_fin) begin
      if (push_ready) begin
        busy <= 1'b0;
      end
    end else begin
      held_valid <= 1'b1;
      held_vel   <= in_vel;
      held_acc   <= in_acc;
      busy       <= 1'b0;
    end
  end

  `VCAF_ASSERT_NEXT(a_div_gap_nonzero, clk, rst,
    push_valid && push_job.op == vcaf_pkg::OP_DIV, $past(push_job.gmag) != '0,
    "front queued a recompute job with a zero velocity gap")

endmodule

// ===== rtl/core/vcaf_queue.sv =====
// ----------------------------------------------------------------------------
// Velocity cap job queue
// Small FIFO of jobs between the front and back parts.
// ----------------------------------------------------------------------------
`include "velocity_cap_accel_fixup_unit_assert.svh"

module vcaf_queue #(
  parameter int DEPTH = vcaf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  vcaf_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vcaf_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  vcaf_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  `VCAF_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= FULL_CNT,
    "queue count beyond its depth")
  `VCAF_ASSERT_NEXT(a_count_drain, clk, rst, pop_fire && !push_fire,
    count == $past(count) - 1'b1, "queue count did not drop on a pop")

endmodule

// ===== rtl/core/vcaf_back.sv =====
// ----------------------------------------------------------------------------
// Velocity cap back part
// Carries out queued jobs: pass, zero, or multiply and divide two bits a step.
// ----------------------------------------------------------------------------
`include "velocity_cap_accel_fixup_unit_assert.svh"

module vcaf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  vcaf_pkg::job_t pop_job,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata,
  output logic           m_tlast
);

  localparam int MW = vcaf_pkg::MAG_W;
  localparam int PW = vcaf_pkg::PROD_W;
  localparam int AW = vcaf_pkg::ACC_W;
  localparam logic [vcaf_pkg::STEP_CNT_W-1:0] LAST_STEP =
    vcaf_pkg::STEP_CNT_W'(vcaf_pkg::DIV_STEPS - 1);
  localparam logic [PW-1:0] Q_POS_LIMIT = PW'(2 ** (AW - 1) - 1);
  localparam logic [PW-1:0] Q_NEG_LIMIT = PW'(2 ** (AW - 1));
  localparam logic [AW-1:0] ACC_MAX = AW'(2 ** (AW - 1) - 1);
  localparam logic [AW-1:0] ACC_MIN = AW'(2 ** (AW - 1));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                          state;
  logic [vcaf_pkg::STEP_CNT_W-1:0] step;
  logic [MW-1:0]                   nmag;
  logic [MW-1:0]                   amag;
  logic [MW-1:0]                   gmag;
  logic                            neg;
  logic [vcaf_pkg::VEL_W-1:0]      job_vel;
  logic [PW-1:0]                   dq;
  logic [MW-1:0]                   rem;
  logic [PW-1:0]                   dq_next;
  logic [MW-1:0]                   rem_next;
  logic [AW-1:0]                   div_acc;
  logic [AW:0]                     neg_q;

  logic                            out_valid;
  logic [vcaf_pkg::VEL_W-1:0]      out_vel;
  logic [AW-1:0]                   out_acc;
  logic                            out_fin;
  logic                            out_free;
  logic                            out_load;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_acc, out_vel};
  assign m_tlast  = out_fin;
  assign pop_ready = (state == S_IDLE) && (pop_job.op == vcaf_pkg::OP_DIV || out_free);
  // The output register takes a simple job straight from the queue or a finished
  // recompute.
  assign out_load = (state == S_IDLE && pop_valid && pop_ready &&
                     pop_job.op != vcaf_pkg::OP_DIV) || (state == S_DONE && out_free);

  // Restoring division, BITS_PER_STEP quotient bits per cycle.
  always_comb begin
    logic [MW:0] wide;
    logic [MW:0] dvs;
    rem_next = rem;
    dq_next  = dq;
    dvs      = {1'b0, gmag};
    for (int i = 0; i < vcaf_pkg::BITS_PER_STEP; i++) begin
      wide = {rem_next, dq_next[PW-1]};
      if (wide >= dvs) begin
        wide    = wide - dvs;
        dq_next = {dq_next[PW-2:0], 1'b1};
      end else begin
        dq_next = {dq_next[PW-2:0], 1'b0};
      end
      rem_next = wide[MW-1:0];
    end
  end

  always_comb begin
    neg_q = -{1'b0, dq[AW-1:0]};
    if (neg) begin
      div_acc = (dq > Q_NEG_LIMIT) ? ACC_MIN : neg_q[AW-1:0];
    end else begin
      div_acc = (dq > Q_POS_LIMIT) ? ACC_MAX : dq[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid && pop_ready) begin
            if (pop_job.op == vcaf_pkg::OP_DIV) begin
              nmag    <= pop_job.nmag;
              amag    <= pop_job.amag;
              gmag    <= pop_job.gmag;
              neg     <= pop_job.neg;
              job_vel <= pop_job.vel;
              state   <= S_MUL;
            end else begin
              out_vel   <= pop_job.vel;
              out_fin   <= pop_job.fin;
              out_acc   <= (pop_job.op == vcaf_pkg::OP_PASS) ? pop_job.accel : '0;
            end
          end
        end
        S_MUL: begin
          dq    <= nmag * amag;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_vel   <= job_vel;
            out_fin   <= 1'b0;
            out_acc   <= div_acc;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VCAF_ASSERT_ALWAYS(a_rem_below_divisor, clk, rst,
    state != S_DIV || rem < gmag, "division remainder reached the divisor")
  `VCAF_ASSERT_NEXT(a_div_ends, clk, rst, state == S_DIV && step == LAST_STEP,
    state == S_DONE, "division did not finish after its last step")

endmodule

// ===== rtl/core/velocity_cap_accel_fixup_unit.sv =====
// Flow: a held point's job goes from the front through the queue to the output register when
//   its acceleration passes or is zeroed, and through the multiply and divide states first when
//   it is recomputed. The front takes no new request while busy with the last one, and stalls
//   on a full queue; the back takes no new job until a recompute has reached the output register.
// Reset (rst, synchronous, active high) empties the queue and output register, drops the
//   held point and loads the velocity cap with 3840.
// ----------------------------------------------------------------------------
// Velocity cap with acceleration fixup
// Caps trajectory point velocities and corrects the accelerations around the cap.
// ----------------------------------------------------------------------------
//
// Structure. The front part holds one point back. When the next request arrives it
// compares both points against the cap and turns the held point into a job: pass its
// acceleration, force it to zero (both above the cap), or recompute it (opposite sides).
// A final request also queues a job for itself with acceleration zero and the final flag.
// Jobs wait in a short queue, so the front keeps taking requests while the back part
// works. The back part passes simple jobs straight to its output register; a recompute
// job multiplies the capped velocity step by the acceleration magnitude in its multiply state,
// then divides by the original velocity gap in a restoring divider that retires two
// quotient bits a cycle, and finally saturates the signed result to 16 bits.
//
// The output register parts the back part from the master side, so one result can wait
// there while the next job is already being worked on.
//
// Configuration. The cap is written through cfg_valid/cfg_ready/cfg_data, which is always
// ready. Users must change it only while the block is idle; the block does not enforce this.

module velocity_cap_accel_fixup_unit #(
  parameter int QUEUE_DEPTH = vcaf_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: cfg_data is max_speed.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vcaf_pkg::CAP_W-1:0] cfg_data,
  // Input points.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // [15:0] point_velocity, [31:16] point_accel
  input  logic                       s_tlast,   // is_final
  // Results.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // [15:0] out_velocity, [31:16] out_accel
  output logic                       m_tlast    // out_final
);

  logic [vcaf_pkg::CAP_W-1:0] max_speed;
  logic                       push_valid;
  logic                       push_ready;
  vcaf_pkg::job_t             push_job;
  logic                       pop_valid;
  logic                       pop_ready;
  vcaf_pkg::job_t             pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= vcaf_pkg::MAX_SPEED_RESET;
    end else if (cfg_valid) begin
      max_speed <= cfg_data;
    end
  end

  vcaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .max_speed  (max_speed),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  vcaf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  vcaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== verif/velocity_cap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity cap result checker
// Watches the cap register, point and result channels, predicts every result
// from its own copy of the held point and the cap, and compares in order.
// ----------------------------------------------------------------------------
module velocity_cap_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [vcaf_pkg::CAP_W-1:0] cfg_data,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [31:0]                s_tdata,   // [15:0] point_velocity, [31:16] point_accel
  input  logic                       s_tlast,   // is_final
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [31:0]                m_tdata,   // [15:0] out_velocity, [31:16] out_accel
  input  logic                       m_tlast,   // out_final
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);

  typedef struct packed {
    logic signed [15:0] vel;
    logic signed [15:0] accel;
    logic               last;
  } traj_result_t;

  traj_result_t expected_points[$];

  logic [vcaf_pkg::CAP_W-1:0] speed_cap;
  int                         held_vel;
  int                         held_acc;
  bit                         held;

  function automatic logic signed [15:0] capped_velocity(input int v, input int cap);
    return 16'((v > cap) ? cap : v);
  endfunction

  // Acceleration of a point given the next velocity: zero when both are over the
  // cap, unchanged when both are at or under it, otherwise scaled by the capped step
  // over the original step (a zero acceleration taken as one), truncated toward zero.
  function automatic logic signed [15:0] fixup_accel(input int vi, input int ai,
                                                      input int vn, input int cap);
    bit     over_i;
    bit     over_n;
    int     num;
    int     gap;
    longint nmag;
    longint amag;
    longint gmag;
    longint q;
    over_i = vi > cap;
    over_n = vn > cap;
    if (over_i && over_n) return 16'sd0;
    if (!over_i && !over_n) return 16'(ai);
    num  = (over_n ? cap : vn) - (over_i ? cap : vi);
    gap  = vn - vi;
    nmag = (num < 0) ? -num : num;
    amag = (ai < 0) ? -ai : ai;
    gmag = (gap < 0) ? -gap : gap;
    if (amag < 1) amag = 1;
    if (gmag == 0) return 16'sd0;
    q = (nmag * amag) / gmag;
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  always @(posedge clk) begin : watch
    int           v_in;
    int           a_in;
    int           cap_i;
    traj_result_t want;
    traj_result_t got;
    if (rst) begin
      expected_points.delete();
      speed_cap  = vcaf_pkg::MAX_SPEED_RESET;
      held_vel   = 0;
      held_acc   = 0;
      held       = 0;
      fail_count = 0;
      checked    = 0;
    end else begin
      // Results leaving at this edge were all predicted at earlier edges.
      if (m_tvalid && m_tready) begin
        got.vel   = m_tdata[15:0];
        got.accel = m_tdata[31:16];
        got.last  = m_tlast;
        if (expected_points.size() == 0) begin
          $error("result with nothing expected: vel %0d accel %0d last %0d",
                 got.vel, got.accel, got.last);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (got.vel !== want.vel) begin
            $error("out_velocity: expected %0d, actual %0d", want.vel, got.vel);
            fail_count++;
          end
          if (got.accel !== want.accel) begin
            $error("out_accel: expected %0d, actual %0d", want.accel, got.accel);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("out_final: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) speed_cap = cfg_data;

      if (s_tvalid && s_tready) begin
        v_in  = $signed(s_tdata[15:0]);
        a_in  = $signed(s_tdata[31:16]);
        cap_i = speed_cap;
        if (held) begin
          want.vel   = capped_velocity(held_vel, cap_i);
          want.accel = fixup_accel(held_vel, held_acc, v_in, cap_i);
          want.last  = 1'b0;
          expected_points = {expected_points, want};
        end
        if (s_tlast) begin
          want.vel   = capped_velocity(v_in, cap_i);
          want.accel = 16'sd0;
          want.last  = 1'b1;
          expected_points = {expected_points, want};
          held_vel = 0;
          held_acc = 0;
          held     = 0;
        end else begin
          held_vel = v_in;
          held_acc = a_in;
          held     = 1;
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity cap unit testbench
// Drives trajectories of points under a range of cap settings, with random gaps
// on both channels, and lets the checker compare every result in order.
// ----------------------------------------------------------------------------
module testbench;

  // Cycles of settling once every expected result is in; covers a point that is
  // still being stored, which produces no result of its own.
  localparam int DRAIN_CYCLES = 30;
  // Long receiver hold-off that fills the queue and stalls the input side.
  localparam int HOLD_CYCLES = 300;
  // Cycles in a row without any accepted request before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES = 7;
  localparam int POINTS_PER_PHASE = 250;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [vcaf_pkg::CAP_W-1:0] cfg_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [31:0]                s_tdata;   // [15:0] point_velocity, [31:16] point_accel
  logic                       s_tlast;   // is_final
  logic                       m_tvalid;
  logic                       m_tready;
  logic [31:0]                m_tdata;   // [15:0] out_velocity, [31:16] out_accel
  logic                       m_tlast;   // out_final

  int fail_count;
  int pending;
  int checked;

  // Stimulus controls shared with the receiver process.
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  int points_sent;
  int trajectories;
  int cap_writes;
  int current_cap;
  int idle_cycles;

  velocity_cap_accel_fixup_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  velocity_cap_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver. Ready is dropped at random, with odds of 23 in a hundred, while idling
  // is on. A hold-off request keeps ready low for a long stretch, counted here.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready = !idle_on || ($urandom_range(99) >= 23);
      end
    end
  end

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no request accepted for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One point request. Valid stays high when the next request follows right away;
  // every caller that waits for anything else lowers it first.
  task automatic send_point(input int v, input int a, input bit fin);
    while (idle_on && $urandom_range(99) < 23) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {a[15:0], v[15:0]};
    s_tlast  = fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    points_sent++;
    if (fin) trajectories++;
  endtask

  // Stop offering points and wait until every predicted result has come out.
  task automatic drain;
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The cap only changes between trajectories with the block drained.
  task automatic write_cap(input int cap);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = cap[vcaf_pkg::CAP_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid   = 1'b0;
    current_cap = cap;
    cap_writes++;
  endtask

  // Velocities cluster around the cap so that crossings are frequent, with a
  // share of full-range values and the field extremes.
  function automatic int random_velocity(input int cap);
    logic [15:0] raw;
    int          x;
    raw = $urandom;
    case ($urandom_range(9))
      0, 1:       x = $signed(raw);
      2, 3, 4, 5: x = cap + int'($urandom_range(600)) - 300;
      6:          x = $urandom_range(1) ? 32767 : -32768;
      7:          x = cap + int'($urandom_range(2)) - 1;
      default:    x = cap + int'($urandom_range(8000)) - 4000;
    endcase
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x;
  endfunction

  function automatic int random_accel();
    logic [15:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $signed(raw);
      5:             return 0;
      6:             return $urandom_range(1) ? 1 : -1;
      7:             return $urandom_range(1) ? 32767 : -32768;
      default:       return int'($urandom_range(1024)) - 512;
    endcase
  endfunction

  task automatic send_trajectory(output int len);
    len = ($urandom_range(99) < 10) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      send_point(random_velocity(current_cap), random_accel(), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int len;
    int phase_points;
    int failures;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    points_sent  = 0;
    trajectories = 0;
    cap_writes   = 0;
    current_cap  = vcaf_pkg::MAX_SPEED_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset cap of 3840.
    // Single-point trajectories: one over the cap, one under it, one at the extremes.
    send_point(5000, 100, 1'b1);
    send_point(-1, -1, 1'b1);
    send_point(-32768, 32767, 1'b1);
    // A trajectory walking through every kind of acceleration fix.
    send_point(0, 0, 1'b0);
    send_point(100, 50, 1'b0);          // under then under: passes
    send_point(4000, 300, 1'b0);        // under then over: recomputed
    send_point(5000, -7, 1'b0);         // over then over: zeroed
    send_point(200, 0, 1'b0);           // over then under; this point carries a zero accel
    send_point(-32768, -32768, 1'b0);   // under then under; this point carries the extreme accel
    send_point(32767, 32767, 1'b0);     // widest crossing, largest accel magnitude
    send_point(-32768, 1, 1'b0);        // over then under across the full range
    send_point(3840, -32768, 1'b0);     // exactly at the cap counts as under
    send_point(3841, 5, 1'b0);          // capped step of zero
    send_point(3840, 9, 1'b1);          // one-LSB gap, then the final point
    // Two points both over the cap ending the trajectory.
    send_point(32767, -1, 1'b0);
    send_point(32767, 77, 1'b1);

    // Random part: one cap setting per phase, the extremes among them.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_cap(0);
        1:       write_cap(32767);
        3:       write_cap(1);
        4:       write_cap(vcaf_pkg::MAX_SPEED_RESET);
        6:       write_cap(16384);
        default: write_cap($urandom_range(32767));
      endcase
      // One phase runs with no gaps at all on either side.
      idle_on = (phase != 2);
      phase_points = 0;
      while (phase_points < POINTS_PER_PHASE) begin
        // Receiver holds off while points keep coming, so the input stalls.
        if (phase == 3 && phase_points == 0) hold_request = 1'b1;
        // Sender pauses mid-phase until every result is in.
        if (phase == 4 && phase_points >= POINTS_PER_PHASE / 2 &&
            phase_points < POINTS_PER_PHASE / 2 + 13) begin
          drain();
        end
        send_trajectory(len);
        phase_points += len;
      end
    end

    idle_on = 1'b1;
    drain();

    failures = fail_count;
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
      failures++;
    end
    $display("Covered %0d points in %0d trajectories over %0d cap settings.",
             points_sent, trajectories, cap_writes + 1);
    $display("Compared %0d results, including a long output stall and a gap-free phase.",
             checked);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
